### rtl/ogpb_pkg.sv
// ----------------------------------------------------------------------------
// ogpb_pkg
// Shared types, codes and the control program of the occupancy grid binner.
// ----------------------------------------------------------------------------
package ogpb_pkg;

  localparam int GRID_SIDE_DEF = 64;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_HALF = 1'b0;
  localparam logic REG_CELL = 1'b1;
  localparam logic [14:0] HALF_RST = 15'd1280;
  localparam logic [12:0] CELL_RST = 13'd40;

  // divider lane: 16-bit dividend, 13-bit divisor
  localparam int QW = 16;
  localparam int DW = 13;
  localparam int CNT_W = $clog2(QW);

  // operation codes
  localparam logic [1:0] OP_BIN = 2'd0;
  localparam logic [1:0] OP_CLR = 2'd1;
  localparam logic [1:0] OP_RD  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [5:0]         read_row;
    logic [5:0]         read_col;
  } req_t;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       in_range;
    logic       cell_value;
  } rsp_t;

  typedef logic [3:0] step_t;

  // program addresses
  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_BIN0 = 4'd1;
  localparam step_t S_BIN1 = 4'd2;
  localparam step_t S_BIN2 = 4'd3;
  localparam step_t S_BIN3 = 4'd4;
  localparam step_t S_CLR  = 4'd5;
  localparam step_t S_RD0  = 4'd6;
  localparam step_t S_RD1  = 4'd7;
  localparam step_t S_EMIT = 4'd8;

  typedef enum logic [3:0] {
    A_NONE,
    A_DIV_LOAD,
    A_DIV_STEP,
    A_ROW_READ,
    A_ROW_WRITE,
    A_CLEAR,
    A_CELL_READ,
    A_CELL_TAKE,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_OUT_WIN,
    C_DIV_MORE,
    C_OFF_GRID,
    C_SLOT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  // control store: jump to target when cond holds, else fall through
  // (back to idle after a step marked last)
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '{act: A_NONE, cond: C_ALWAYS, target: S_IDLE, last: 1'b1};
    unique case (step)
      S_IDLE: c = '{act: A_NONE,      cond: C_DISPATCH,  target: S_IDLE, last: 1'b0};
      S_BIN0: c = '{act: A_DIV_LOAD,  cond: C_OUT_WIN,   target: S_EMIT, last: 1'b0};
      S_BIN1: c = '{act: A_DIV_STEP,  cond: C_DIV_MORE,  target: S_BIN1, last: 1'b0};
      S_BIN2: c = '{act: A_ROW_READ,  cond: C_OFF_GRID,  target: S_EMIT, last: 1'b0};
      S_BIN3: c = '{act: A_ROW_WRITE, cond: C_ALWAYS,    target: S_EMIT, last: 1'b0};
      S_CLR:  c = '{act: A_CLEAR,     cond: C_ALWAYS,    target: S_EMIT, last: 1'b0};
      S_RD0:  c = '{act: A_CELL_READ, cond: C_NEVER,     target: S_IDLE, last: 1'b0};
      S_RD1:  c = '{act: A_CELL_TAKE, cond: C_NEVER,     target: S_IDLE, last: 1'b0};
      S_EMIT: c = '{act: A_EMIT,      cond: C_SLOT_BUSY, target: S_EMIT, last: 1'b1};
      default: c = '{act: A_NONE,     cond: C_ALWAYS,    target: S_IDLE, last: 1'b1};
    endcase
    return c;
  endfunction

  function automatic step_t dispatch(input logic [1:0] op);
    step_t s;
    unique case (op)
      OP_BIN:  s = S_BIN0;
      OP_CLR:  s = S_CLR;
      OP_RD:   s = S_RD0;
      default: s = S_EMIT;
    endcase
    return s;
  endfunction

endpackage

### rtl/ogpb_ram.sv
// ----------------------------------------------------------------------------
// ogpb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ogpb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/occupancy_grid_point_binner_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_point_binner_top
// Bins fixed-point 2-D points into a square one-bit occupancy map.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. For a bin request whose point
// lands on the grid, two restoring divider lanes (row and column) retire one
// quotient bit per cycle, then a read-modify-write of one map row follows; a
// point that divides off the grid skips the write. An out-of-window point
// (any point when the cell size is zero) skips the divider. A held response
// that stays stalled holds the emit step. The map is a RAM of GRID_SIDE rows
// of GRID_SIDE bits; a per-row valid bit stands in for clearing it, so no
// clearing pass follows reset. A finished response waits in an output
// register while the next request is accepted.
module occupancy_grid_point_binner_top #(
  parameter int GRID_SIDE = ogpb_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ogpb_pkg::req_t              req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ogpb_pkg::rsp_t              rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ogpb_pkg::ADDR_W-1:0] paddr,
  input  logic [ogpb_pkg::DATA_W-1:0] pwdata,
  output logic [ogpb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int IW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int QW = ogpb_pkg::QW;
  localparam int DW = ogpb_pkg::DW;

  // configuration
  logic [14:0] half_length;
  logic [12:0] cell_size;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= ogpb_pkg::HALF_RST;
      cell_size   <= ogpb_pkg::CELL_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ogpb_pkg::REG_HALF) begin
        half_length <= pwdata[14:0];
      end else begin
        cell_size <= pwdata[12:0];
      end
    end
  end

  assign prdata = (paddr[2] == ogpb_pkg::REG_CELL) ? {19'd0, cell_size} : {17'd0, half_length};

  // sequencer
  ogpb_pkg::step_t pc;
  ogpb_pkg::step_t pc_next;
  ogpb_pkg::ctrl_t cw;
  logic            accept;
  logic            cond_true;

  localparam int CNT_W_L = ogpb_pkg::CNT_W;
  ogpb_pkg::req_t item;
  logic [CNT_W_L-1:0] cnt;

  logic [DW-1:0] rem_r, rem_c;
  logic [QW-1:0] dvd_r, dvd_c;

  logic [IW-1:0]        row_idx, col_idx;
  logic [GRID_SIDE-1:0] row_vld;
  logic [GRID_SIDE-1:0] ram_rdata;
  logic [GRID_SIDE-1:0] ram_wdata;
  logic [GRID_SIDE-1:0] col_mask;
  logic [IW-1:0]        ram_raddr;
  logic                 ram_we;

  logic [5:0] res_row, res_col;
  logic       res_hit, res_val;

  // window check on the held point
  logic signed [17:0] hs, xs, ys;
  logic signed [17:0] x_lo, x_hi, y_lo, y_hi;
  logic               win_ok;
  logic               grid_ok;
  logic               rd_ok;
  logic [8:0]         rd_row9, rd_col9;
  logic               slot_busy;

  assign hs   = {3'b000, half_length};
  assign xs   = 18'(item.point_x);
  assign ys   = 18'(item.point_y);
  assign x_hi = hs - xs;
  assign x_lo = hs + xs;
  assign y_hi = hs - ys;
  assign y_lo = hs + ys;
  assign win_ok = (cell_size != 13'd0) && !x_hi[17] && !x_lo[17] && !y_hi[17] && !y_lo[17];

  assign grid_ok = (dvd_r < QW'(GRID_SIDE)) && (dvd_c < QW'(GRID_SIDE));

  assign rd_row9 = {3'b000, item.read_row};
  assign rd_col9 = {3'b000, item.read_col};
  assign rd_ok   = (rd_row9 < 9'(GRID_SIDE)) && (rd_col9 < 9'(GRID_SIDE));

  assign slot_busy = rsp_valid && rsp_stall;
  assign req_stall = (pc != ogpb_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cw = ogpb_pkg::ucode(pc);
    unique case (cw.cond)
      ogpb_pkg::C_NEVER:     cond_true = 1'b0;
      ogpb_pkg::C_ALWAYS:    cond_true = 1'b1;
      ogpb_pkg::C_DISPATCH:  cond_true = accept;
      ogpb_pkg::C_OUT_WIN:   cond_true = !win_ok;
      ogpb_pkg::C_DIV_MORE:  cond_true = (cnt != '0);
      ogpb_pkg::C_OFF_GRID:  cond_true = !grid_ok;
      ogpb_pkg::C_SLOT_BUSY: cond_true = slot_busy;
      default:               cond_true = 1'b0;
    endcase
    priority if (cw.cond == ogpb_pkg::C_DISPATCH) begin
      pc_next = accept ? ogpb_pkg::dispatch(req_data.op) : ogpb_pkg::S_IDLE;
    end else if (cond_true) begin
      pc_next = cw.target;
    end else if (cw.last) begin
      pc_next = ogpb_pkg::S_IDLE;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ogpb_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // divider lanes: shift in one dividend bit, subtract when it fits
  logic [DW:0] sh_r, sh_c, dv;
  logic        fit_r, fit_c;

  assign dv    = {1'b0, cell_size};
  assign sh_r  = {rem_r, dvd_r[QW-1]};
  assign sh_c  = {rem_c, dvd_c[QW-1]};
  assign fit_r = (sh_r >= dv);
  assign fit_c = (sh_c >= dv);

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_data;
    end
    unique case (cw.act)
      ogpb_pkg::A_DIV_LOAD: begin
        rem_r <= '0;
        rem_c <= '0;
        dvd_r <= x_hi[QW-1:0];
        dvd_c <= y_hi[QW-1:0];
        cnt   <= CNT_W_L'(QW - 1);
      end
      ogpb_pkg::A_DIV_STEP: begin
        rem_r <= fit_r ? DW'(sh_r - dv) : sh_r[DW-1:0];
        rem_c <= fit_c ? DW'(sh_c - dv) : sh_c[DW-1:0];
        dvd_r <= {dvd_r[QW-2:0], fit_r};
        dvd_c <= {dvd_c[QW-2:0], fit_c};
        cnt   <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // results and map indices
  always_ff @(posedge clk) begin
    if (accept) begin
      res_row <= '0;
      res_col <= '0;
      res_hit <= 1'b0;
      res_val <= 1'b0;
    end else begin
      unique case (cw.act)
        ogpb_pkg::A_ROW_READ: begin
          if (grid_ok) begin
            res_row <= dvd_r[5:0];
            res_col <= dvd_c[5:0];
            res_hit <= 1'b1;
          end
          row_idx <= dvd_r[IW-1:0];
          col_idx <= dvd_c[IW-1:0];
        end
        ogpb_pkg::A_CELL_READ: begin
          row_idx <= rd_row9[IW-1:0];
          col_idx <= rd_col9[IW-1:0];
        end
        ogpb_pkg::A_CELL_TAKE: begin
          res_val <= rd_ok && row_vld[row_idx] && ram_rdata[col_idx];
        end
        default: begin
        end
      endcase
    end
  end

  // row valid bits stand in for clearing the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cw.act == ogpb_pkg::A_CLEAR) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[row_idx] <= 1'b1;
    end
  end

  assign ram_raddr = (cw.act == ogpb_pkg::A_CELL_READ) ? rd_row9[IW-1:0] : dvd_r[IW-1:0];
  assign ram_we    = (cw.act == ogpb_pkg::A_ROW_WRITE);
  assign col_mask  = {{(GRID_SIDE-1){1'b0}}, 1'b1} << col_idx;
  assign ram_wdata = (row_vld[row_idx] ? ram_rdata : '0) | col_mask;

  ogpb_ram #(
    .WIDTH(GRID_SIDE),
    .DEPTH(GRID_SIDE),
    .AW   (IW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row_idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cw.act == ogpb_pkg::A_EMIT && !slot_busy) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ogpb_pkg::A_EMIT && !slot_busy) begin
      rsp_data <= '{cell_row: res_row, cell_col: res_col, in_range: res_hit,
                    cell_value: res_val};
    end
  end

  // checks
  a_rsp_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pc) == ogpb_pkg::S_EMIT)
    else $error("response loaded outside the emit step");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    cw.act == ogpb_pkg::A_CLEAR |=> row_vld == '0)
    else $error("row valid bits survive a clear");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    pc == ogpb_pkg::S_BIN2 |-> (rem_r < cell_size) && (rem_c < cell_size))
    else $error("divider remainder not below cell size");

  a_write_hit: assert property (@(posedge clk) disable iff (rst)
    pc == ogpb_pkg::S_BIN3 |-> res_hit && !req_stall == 1'b0)
    else $error("map row written for a point off the grid");

endmodule
